/* hw/rtl/cpfv_pkg.sv */
// Shared widths, constants and stage type of the taxpayer number check-digit validator.
package cpfv_pkg;

  localparam int NUM_W    = 37;
  localparam int TDATA_W  = 40;
  localparam int DIGITS   = 12;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int BODY     = 10;
  localparam int HALF     = BODY / 2;
  localparam int SUM_W    = 10;
  localparam int Q_W      = 7;
  localparam int PROD_W   = SUM_W + 10;
  localparam int RECIP    = 745;
  localparam int RECIP_SH = 13;
  localparam int MODULUS  = 11;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [NUM_W-1:0] sh;
    logic [NUM_W-1:0] num;
  } dd_data_t;

endpackage

/* hw/rtl/cpfv_cell.sv */
// One shift-and-adjust cell of the binary-to-decimal conversion chain.
module cpfv_cell
  import cpfv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  dd_data_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output dd_data_t dn_data
);

  logic             valid_r;
  dd_data_t         data_r;
  dd_data_t         data_nxt;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      if (up_data.bcd[4*j +: 4] >= 4'd5) begin
        adj[4*j +: 4] = up_data.bcd[4*j +: 4] + 4'd3;
      end else begin
        adj[4*j +: 4] = up_data.bcd[4*j +: 4];
      end
    end
    data_nxt.bcd = {adj[BCD_W-2:0], up_data.sh[NUM_W-1]};
    data_nxt.sh  = {up_data.sh[NUM_W-2:0], 1'b0};
    data_nxt.num = up_data.num;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hw/rtl/cpfv_check.sv */
// Weighted sums, modulo-11 reduction and check-digit comparison over the decimal digits.
module cpfv_check
  import cpfv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  dd_data_t         up_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_valid,
  output logic [NUM_W-1:0] out_num
);

  typedef struct packed {
    logic [SUM_W-1:0] p1a;
    logic [SUM_W-1:0] p1b;
    logic [SUM_W-1:0] p2a;
    logic [SUM_W-1:0] p2b;
    logic [3:0]       d1;
    logic [3:0]       d2;
    logic [NUM_W-1:0] num;
  } st1_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum2;
    logic [3:0]       d1;
    logic [3:0]       d2;
    logic [NUM_W-1:0] num;
  } st2_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum2;
    logic [Q_W-1:0]   q1;
    logic [Q_W-1:0]   q2;
    logic [3:0]       d1;
    logic [3:0]       d2;
    logic [NUM_W-1:0] num;
  } st3_t;

  function automatic logic digit_ok(input logic [SUM_W-1:0] s, input logic [Q_W-1:0] q,
                                    input logic [3:0] d);
    logic [SUM_W-1:0] r;
    logic [3:0]       rn;
    r = s - SUM_W'(q) * SUM_W'(MODULUS);
    if (r >= SUM_W'(MODULUS)) begin
      r = r - SUM_W'(MODULUS);
    end
    rn = r[3:0];
    if (rn < 4'd2) begin
      return d == 4'd0;
    end
    return d == (4'(MODULUS) - rn);
  endfunction

  logic             v1_r;
  logic             v2_r;
  logic             v3_r;
  logic             vo_r;
  logic             rdy1;
  logic             rdy2;
  logic             rdy3;
  logic             rdyo;
  st1_t             st1_r;
  st1_t             st1_nxt;
  st2_t             st2_r;
  st2_t             st2_nxt;
  st3_t             st3_r;
  st3_t             st3_nxt;
  logic [PROD_W-1:0] m1;
  logic [PROD_W-1:0] m2;
  logic             ok_r;
  logic             ok_nxt;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] num_nxt;

  assign rdyo     = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdyo;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    st1_nxt.p1a = '0;
    st1_nxt.p1b = '0;
    st1_nxt.d1  = up_data.bcd[7:4];
    st1_nxt.d2  = up_data.bcd[3:0];
    st1_nxt.p2a = SUM_W'(up_data.bcd[7:4]) * SUM_W'(2);
    st1_nxt.p2b = '0;
    st1_nxt.num = up_data.num;
    for (int k = 0; k < HALF; k++) begin
      st1_nxt.p1a = st1_nxt.p1a + SUM_W'(up_data.bcd[4*(k+2) +: 4]) * SUM_W'(k + 2);
      st1_nxt.p2a = st1_nxt.p2a + SUM_W'(up_data.bcd[4*(k+2) +: 4]) * SUM_W'(k + 3);
      st1_nxt.p1b = st1_nxt.p1b
                    + SUM_W'(up_data.bcd[4*(k+HALF+2) +: 4]) * SUM_W'(k + HALF + 2);
      st1_nxt.p2b = st1_nxt.p2b
                    + SUM_W'(up_data.bcd[4*(k+HALF+2) +: 4]) * SUM_W'(k + HALF + 3);
    end
  end

  always_comb begin
    st2_nxt.sum1 = st1_r.p1a + st1_r.p1b;
    st2_nxt.sum2 = st1_r.p2a + st1_r.p2b;
    st2_nxt.d1   = st1_r.d1;
    st2_nxt.d2   = st1_r.d2;
    st2_nxt.num  = st1_r.num;
  end

  always_comb begin
    m1           = PROD_W'(st2_r.sum1) * PROD_W'(RECIP);
    m2           = PROD_W'(st2_r.sum2) * PROD_W'(RECIP);
    st3_nxt.sum1 = st2_r.sum1;
    st3_nxt.sum2 = st2_r.sum2;
    st3_nxt.q1   = m1[RECIP_SH +: Q_W];
    st3_nxt.q2   = m2[RECIP_SH +: Q_W];
    st3_nxt.d1   = st2_r.d1;
    st3_nxt.d2   = st2_r.d2;
    st3_nxt.num  = st2_r.num;
  end

  always_comb begin
    ok_nxt  = digit_ok(st3_r.sum1, st3_r.q1, st3_r.d1)
              && digit_ok(st3_r.sum2, st3_r.q2, st3_r.d2);
    num_nxt = ok_nxt ? st3_r.num : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdyo) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      st1_r <= st1_nxt;
    end
    if (rdy2 && v1_r) begin
      st2_r <= st2_nxt;
    end
    if (rdy3 && v2_r) begin
      st3_r <= st3_nxt;
    end
    if (rdyo && v3_r) begin
      ok_r  <= ok_nxt;
      num_r <= num_nxt;
    end
  end

  assign out_valid    = vo_r;
  assign out_is_valid = ok_r;
  assign out_num      = num_r;

endmodule

/* hw/rtl/cpf_check_digit_validator.sv */
// Top level of the taxpayer number check-digit validator.
//
//   Channel  Direction  Payload
//   in_      slave      tdata: cpf_number
//   out_     master     tdata: accepted_number; tuser: is_valid
//
// One number is accepted in every cycle unless a low out_tready stalls the pipeline.
// Each number passes the chain of 37 conversion cells, one per input bit, and four check stages.
// Each stage holds its transaction while the next one is full, so a stall only fills the gaps.
// Reset clears the valid flags of all stages; payload registers keep their contents.
module cpf_check_digit_validator
  import cpfv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [36:0] cpf_number
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [36:0] accepted_number
  output logic               out_tuser   // [0] is_valid
);

  logic             chain_valid [NUM_W+1];
  logic             chain_ready [NUM_W+1];
  dd_data_t         chain_data  [NUM_W+1];
  logic [NUM_W-1:0] num;

  assign chain_valid[0]    = in_tvalid;
  assign in_tready         = chain_ready[0];
  assign chain_data[0].bcd = '0;
  assign chain_data[0].sh  = in_tdata[NUM_W-1:0];
  assign chain_data[0].num = in_tdata[NUM_W-1:0];

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    cpfv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  cpfv_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (chain_valid[NUM_W]),
    .up_ready     (chain_ready[NUM_W]),
    .up_data      (chain_data[NUM_W]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_is_valid (out_tuser),
    .out_num      (num)
  );

  assign out_tdata = {{(TDATA_W-NUM_W){1'b0}}, num};

endmodule
